### sv/bkvm_pkg.sv
// Shared types, codes and defaults for the bounded key-value map.
`default_nettype none
package bkvm_pkg;

   localparam int DEF_TABLE_DEPTH = 64;
   localparam int DEF_KEY_BITS    = 64;
   localparam int DEF_VALUE_BITS  = 64;

   localparam int KEY_FIELD_BITS   = 64;
   localparam int VALUE_FIELD_BITS = 64;
   localparam int CAP_BITS         = 7;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_UPDATE = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EXISTS    = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LAUNCH = 5'b00010,
      S_SCAN   = 5'b00100,
      S_MOVE   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      action_type                  action;
      logic [KEY_FIELD_BITS-1:0]   lookup_key;
      logic [VALUE_FIELD_BITS-1:0] new_value;
      logic [1:0]                  update_mode;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic                        hit;
      logic [VALUE_FIELD_BITS-1:0] found_value;
   } rsp_type;

endpackage
`default_nettype wire

### sv/bounded_key_value_map_unit.sv
// Bounded key-value map top level: sequencer, key/value memories and checks.
//
// The block keeps up to min(capacity_limit, TABLE_DEPTH) unique keys as a dense list.
// A request on req_ is a lookup, an update (overwrite or append), a no-op or a
// delete (the last entry moves into the freed slot). Each request gives exactly one
// result on the rsp_ channel with a status, a hit flag and, on a lookup hit, the value.
// One request is in work at a time; req_stall is high from the cycle after a transfer
// until the result has been loaded into the output register.
// The single read port of the key memory sets the scan speed: one stored key is
// compared per cycle. The next request can transfer once the result is loaded.
// A new request may be taken while the last result waits.
// The csr_ port writes capacity_limit; write it only while the block is idle.
// Reset empties the table, sets capacity_limit to 64 and drops any pending result;
// no clearing pass is needed. If the receiver stalls, the result holds in the output
// register and the next request finishes its work and waits until it can be loaded.
`default_nettype none
module bounded_key_value_map_unit #(
   parameter int TABLE_DEPTH = bkvm_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = bkvm_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS  = bkvm_pkg::DEF_VALUE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire bkvm_pkg::req_type             req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output bkvm_pkg::rsp_type                  rsp_payload,
   input  wire logic                          csr_wr_en,
   input  wire logic [bkvm_pkg::CAP_BITS-1:0] csr_wr_data
);

   localparam int AddrBits = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic                  mem_rd_en;
   logic [AddrBits-1:0]   mem_rd_addr;
   logic                  mem_wr_key_en;
   logic                  mem_wr_val_en;
   logic [AddrBits-1:0]   mem_wr_addr;
   logic [KEY_BITS-1:0]   mem_wr_key;
   logic [VALUE_BITS-1:0] mem_wr_val;
   logic [KEY_BITS-1:0]   mem_rd_key;
   logic [VALUE_BITS-1:0] mem_rd_val;

   bkvm_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_wr_key_en (mem_wr_key_en),
      .mem_wr_val_en (mem_wr_val_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_key    (mem_wr_key),
      .mem_wr_val    (mem_wr_val),
      .mem_rd_key    (mem_rd_key),
      .mem_rd_val    (mem_rd_val)
   );

   bkvm_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_store (
      .clock     (clock),
      .rd_en     (mem_rd_en),
      .rd_addr   (mem_rd_addr),
      .wr_key_en (mem_wr_key_en),
      .wr_val_en (mem_wr_val_en),
      .wr_addr   (mem_wr_addr),
      .wr_key    (mem_wr_key),
      .wr_val    (mem_wr_val),
      .rd_key    (mem_rd_key),
      .rd_val    (mem_rd_val)
   );

   // Only one request is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in work");

   // A full table is only reported for an absent key.
   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.hit && rsp_payload.status == bkvm_pkg::ST_FULL))
      else $error("table full reported together with a hit");

   // A value is only returned by a successful hit.
   a_value_on_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.found_value != '0) |->
      (rsp_payload.hit && rsp_payload.status == bkvm_pkg::ST_OK))
      else $error("value returned without a successful hit");

   // Reset drops any pending result.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

### sv/bkvm_store.sv
// Key and value memories with one write port and one registered read port.
`default_nettype none
module bkvm_store #(
   parameter int TABLE_DEPTH = bkvm_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = bkvm_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS  = bkvm_pkg::DEF_VALUE_BITS,
   localparam int AddrBits   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [AddrBits-1:0]   rd_addr,
   input  wire logic                  wr_key_en,
   input  wire logic                  wr_val_en,
   input  wire logic [AddrBits-1:0]   wr_addr,
   input  wire logic [KEY_BITS-1:0]   wr_key,
   input  wire logic [VALUE_BITS-1:0] wr_val,
   output logic      [KEY_BITS-1:0]   rd_key,
   output logic      [VALUE_BITS-1:0] rd_val
);

   logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] value_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (wr_val_en) begin
         value_mem[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         rd_key <= key_mem[rd_addr];
         rd_val <= value_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### sv/bkvm_ctrl.sv
// Request sequencer: scans the stored keys, applies the update or delete, holds the result.
`default_nettype none
module bkvm_ctrl #(
   parameter int TABLE_DEPTH = bkvm_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = bkvm_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS  = bkvm_pkg::DEF_VALUE_BITS,
   localparam int AddrBits   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire bkvm_pkg::req_type             req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output bkvm_pkg::rsp_type                  rsp_payload,
   input  wire logic                          csr_wr_en,
   input  wire logic [bkvm_pkg::CAP_BITS-1:0] csr_wr_data,
   output logic                               mem_rd_en,
   output logic      [AddrBits-1:0]           mem_rd_addr,
   output logic                               mem_wr_key_en,
   output logic                               mem_wr_val_en,
   output logic      [AddrBits-1:0]           mem_wr_addr,
   output logic      [KEY_BITS-1:0]           mem_wr_key,
   output logic      [VALUE_BITS-1:0]         mem_wr_val,
   input  wire logic [KEY_BITS-1:0]           mem_rd_key,
   input  wire logic [VALUE_BITS-1:0]         mem_rd_val
);

   localparam int CntBits = $clog2(TABLE_DEPTH + 1);
   localparam int CmpBits = (CntBits > bkvm_pkg::CAP_BITS) ? CntBits : bkvm_pkg::CAP_BITS;

   bkvm_pkg::state_type              state_ff, state_in;
   bkvm_pkg::action_type             action_ff, action_in;
   logic [1:0]                       mode_ff, mode_in;
   logic [KEY_BITS-1:0]              key_ff, key_in;
   logic [VALUE_BITS-1:0]            val_ff, val_in;
   logic [AddrBits-1:0]              idx_ff, idx_in;
   logic [AddrBits-1:0]              slot_ff, slot_in;
   logic [CntBits-1:0]               count_ff, count_in;
   logic [bkvm_pkg::CAP_BITS-1:0]    cap_ff, cap_in;
   bkvm_pkg::rsp_type                res_ff, res_in;
   bkvm_pkg::rsp_type                rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic                             full;
   logic [AddrBits-1:0]              last_idx;
   logic                             at_end;

   assign full = (CmpBits'(count_ff) >= CmpBits'(cap_ff)) ||
                 (count_ff == CntBits'(TABLE_DEPTH));
   assign last_idx = AddrBits'(count_ff - CntBits'(1));
   assign at_end   = (idx_ff == last_idx);

   assign req_stall   = (state_ff != bkvm_pkg::S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      count_in      = count_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = AddrBits'(idx_ff + AddrBits'(1));
      mem_wr_key_en = 1'b0;
      mem_wr_val_en = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_key    = key_ff;
      mem_wr_val    = val_ff;

      case (state_ff)
         bkvm_pkg::S_IDLE: begin
            if (req_valid) begin
               action_in = req_payload.action;
               mode_in   = req_payload.update_mode;
               key_in    = req_payload.lookup_key[KEY_BITS-1:0];
               val_in    = req_payload.new_value[VALUE_BITS-1:0];
               state_in  = bkvm_pkg::S_LAUNCH;
            end
         end
         bkvm_pkg::S_LAUNCH, bkvm_pkg::S_SCAN: begin
            res_in.status      = bkvm_pkg::ST_OK;
            res_in.hit         = 1'b0;
            res_in.found_value = '0;
            if (action_ff == bkvm_pkg::ACT_NOP) begin
               state_in = bkvm_pkg::S_FINISH;
            end else if (state_ff == bkvm_pkg::S_LAUNCH && count_ff != '0) begin
               // Start the scan at the first entry.
               mem_rd_en   = 1'b1;
               mem_rd_addr = '0;
               idx_in      = '0;
               state_in    = bkvm_pkg::S_SCAN;
            end else if (state_ff == bkvm_pkg::S_SCAN && mem_rd_key == key_ff) begin
               res_in.hit = 1'b1;
               state_in   = bkvm_pkg::S_FINISH;
               case (action_ff)
                  bkvm_pkg::ACT_LOOKUP: begin
                     res_in.found_value = bkvm_pkg::VALUE_FIELD_BITS'(mem_rd_val);
                  end
                  bkvm_pkg::ACT_UPDATE: begin
                     if (mode_ff[0]) begin
                        res_in.status = bkvm_pkg::ST_EXISTS;
                     end else begin
                        mem_wr_val_en = 1'b1;
                     end
                  end
                  default: begin
                     // Delete: fetch the last entry so it can fill the freed slot.
                     slot_in     = idx_ff;
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = last_idx;
                     state_in    = bkvm_pkg::S_MOVE;
                  end
               endcase
            end else if (state_ff == bkvm_pkg::S_LAUNCH || at_end) begin
               // The key is absent from the table.
               state_in = bkvm_pkg::S_FINISH;
               if (action_ff != bkvm_pkg::ACT_UPDATE || mode_ff[1]) begin
                  res_in.status = bkvm_pkg::ST_NOT_FOUND;
               end else if (full) begin
                  res_in.status = bkvm_pkg::ST_FULL;
               end else begin
                  mem_wr_key_en = 1'b1;
                  mem_wr_val_en = 1'b1;
                  mem_wr_addr   = count_ff[AddrBits-1:0];
                  count_in      = count_ff + CntBits'(1);
               end
            end else begin
               mem_rd_en = 1'b1;
               idx_in    = AddrBits'(idx_ff + AddrBits'(1));
            end
         end
         bkvm_pkg::S_MOVE: begin
            mem_wr_key_en = 1'b1;
            mem_wr_val_en = 1'b1;
            mem_wr_addr   = slot_ff;
            mem_wr_key    = mem_rd_key;
            mem_wr_val    = mem_rd_val;
            count_in      = count_ff - CntBits'(1);
            state_in      = bkvm_pkg::S_FINISH;
         end
         bkvm_pkg::S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = bkvm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bkvm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bkvm_pkg::S_IDLE;
         count_ff     <= '0;
         cap_ff       <= bkvm_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      slot_ff   <= slot_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

endmodule
`default_nettype wire
